FILE: hdl/stuffed_info_frame_encoder_macros.svh
// Assertion macros shared by the frame encoder modules.
`ifndef STUFFED_INFO_FRAME_ENCODER_MACROS_SVH
`define STUFFED_INFO_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sife_pkg.sv
package sife_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG_VALUE        = 3'd0,
    CFG_ESCAPE_VALUE      = 3'd1,
    CFG_FLAG_SUBSTITUTE   = 3'd2,
    CFG_ESCAPE_SUBSTITUTE = 3'd3,
    CFG_ADDRESS_VALUE     = 3'd4,
    CFG_CONTROL_SEQ_ZERO  = 3'd5,
    CFG_CONTROL_SEQ_ONE   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
    logic [7:0] address_value;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       sequence_bit;
    logic       first;
    logic [7:0] check;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } hold_t;

  typedef struct packed {
    logic load;
    logic first;
  } load_t;

endpackage

FILE: hdl/stuffed_info_frame_encoder.sv
// Information frame encoder: payload bytes enter one per transaction with the last one marked;
// the line side leaves one byte per transaction, frame_end_o marking the closing flag. The
// first byte of a frame adds flag, address, control and header check ahead of it; each
// payload byte leaves as one byte, or two when it equals the flag or escape value; the last
// byte adds the stuffed XOR check (one or two bytes) and the closing flag. An item thus
// yields 1 to 9 line bytes, one per cycle while out_stall_i is low, and the next item is
// taken in the same cycle that the current item's final byte enters the output register, so
// the sustained rate is set by the byte-wide output port alone. cfg_ready_o is always high;
// the user must make configuration writes only while no frame byte is pending (unenforced).
module stuffed_info_frame_encoder import sife_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               sequence_bit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               frame_end_o
);

  cfg_t  cfg;
  hold_t hold;
  load_t load;
  logic  done;

  sife_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sife_frame_ctl u_frame_ctl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .sequence_bit_i (sequence_bit_i),
    .done_i         (done),
    .hold_o         (hold),
    .load_o         (load)
  );

  sife_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .hold_i      (hold),
    .load_i      (load),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

FILE: hdl/sife_cfg_regs.sv
module sife_cfg_regs import sife_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FLAG_VALUE:        cfg_d.flag_value        = cfg_data_i;
        CFG_ESCAPE_VALUE:      cfg_d.escape_value      = cfg_data_i;
        CFG_FLAG_SUBSTITUTE:   cfg_d.flag_substitute   = cfg_data_i;
        CFG_ESCAPE_SUBSTITUTE: cfg_d.escape_substitute = cfg_data_i;
        CFG_ADDRESS_VALUE:     cfg_d.address_value     = cfg_data_i;
        CFG_CONTROL_SEQ_ZERO:  cfg_d.control_seq_zero  = cfg_data_i;
        CFG_CONTROL_SEQ_ONE:   cfg_d.control_seq_one   = cfg_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_value        <= 8'd126;
      cfg_q.escape_value      <= 8'd125;
      cfg_q.flag_substitute   <= 8'd94;
      cfg_q.escape_substitute <= 8'd93;
      cfg_q.address_value     <= 8'd3;
      cfg_q.control_seq_zero  <= 8'd0;
      cfg_q.control_seq_one   <= 8'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hdl/sife_frame_ctl.sv
`include "stuffed_info_frame_encoder_macros.svh"

module sife_frame_ctl import sife_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       sequence_bit_i,
  input  logic       done_i,
  output hold_t      hold_o,
  output load_t      load_o
);

  logic       hold_valid_q;
  logic       hold_valid_d;
  item_t      item_q;
  item_t      item_d;
  logic       inside_q;
  logic       inside_d;
  logic [7:0] check_q;
  logic [7:0] check_d;
  logic       load;
  logic [7:0] check_new;

  assign in_stall_o = hold_valid_q && !done_i;
  assign load       = in_valid_i && !in_stall_o;
  assign check_new  = (inside_q ? check_q : 8'd0) ^ data_byte_i;

  assign hold_o.valid  = hold_valid_q;
  assign hold_o.item   = item_q;
  assign load_o.load   = load;
  assign load_o.first  = !inside_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    item_d       = item_q;
    inside_d     = inside_q;
    check_d      = check_q;
    if (done_i) begin
      hold_valid_d = 1'b0;
    end
    if (load) begin
      hold_valid_d        = 1'b1;
      item_d.data_byte    = data_byte_i;
      item_d.last_byte    = last_byte_i;
      item_d.sequence_bit = sequence_bit_i;
      item_d.first        = !inside_q;
      item_d.check        = check_new;
      inside_d            = !last_byte_i;
      check_d             = last_byte_i ? 8'd0 : check_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      inside_q     <= 1'b0;
      check_q      <= 8'd0;
    end else begin
      hold_valid_q <= hold_valid_d;
      inside_q     <= inside_d;
      check_q      <= check_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  `SIFE_ASSERT_NEXT(a_load_fills_hold, load, hold_valid_q, "accepted transaction not held")
  `SIFE_ASSERT_NEXT(a_last_closes_frame, load && last_byte_i, !inside_q && (check_q == 8'd0),
    "frame state not cleared after last byte")

endmodule

FILE: hdl/sife_emitter.sv
`include "stuffed_info_frame_encoder_macros.svh"

module sife_emitter import sife_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  hold_t      hold_i,
  input  load_t      load_i,
  output logic       done_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o
);

  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_HCS,
    PH_DATA,
    PH_DSUB,
    PH_CHK,
    PH_CSUB,
    PH_CLOSE
  } phase_e;

  phase_e     phase_q;
  phase_e     phase_d;
  phase_e     phase_nxt;
  logic       out_valid_q;
  logic       out_valid_d;
  logic [7:0] out_byte_q;
  logic [7:0] out_byte_d;
  logic       frame_end_q;
  logic       frame_end_d;
  logic       emit;
  logic       final_byte;
  logic [7:0] ctrl;
  logic       data_is_flag;
  logic       data_stuffed;
  logic       chk_is_flag;
  logic       chk_stuffed;
  logic [7:0] line_byte;
  logic       line_end;

  assign ctrl         = hold_i.item.sequence_bit ? cfg_i.control_seq_one : cfg_i.control_seq_zero;
  assign data_is_flag = hold_i.item.data_byte == cfg_i.flag_value;
  assign data_stuffed = data_is_flag || (hold_i.item.data_byte == cfg_i.escape_value);
  assign chk_is_flag  = hold_i.item.check == cfg_i.flag_value;
  assign chk_stuffed  = chk_is_flag || (hold_i.item.check == cfg_i.escape_value);

  assign emit   = hold_i.valid && (!out_valid_q || !out_stall_i);
  assign done_o = emit && final_byte;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

  always_comb begin
    line_byte  = cfg_i.flag_value;
    line_end   = 1'b0;
    final_byte = 1'b0;
    phase_nxt  = PH_FLAG;
    case (phase_q)
      PH_FLAG: begin
        line_byte = cfg_i.flag_value;
        phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        line_byte = cfg_i.address_value;
        phase_nxt = PH_CTRL;
      end
      PH_CTRL: begin
        line_byte = ctrl;
        phase_nxt = PH_HCS;
      end
      PH_HCS: begin
        line_byte = cfg_i.address_value ^ ctrl;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        line_byte  = data_stuffed ? cfg_i.escape_value : hold_i.item.data_byte;
        phase_nxt  = data_stuffed ? PH_DSUB : PH_CHK;
        final_byte = !data_stuffed && !hold_i.item.last_byte;
      end
      PH_DSUB: begin
        line_byte  = data_is_flag ? cfg_i.flag_substitute : cfg_i.escape_substitute;
        phase_nxt  = PH_CHK;
        final_byte = !hold_i.item.last_byte;
      end
      PH_CHK: begin
        line_byte = chk_stuffed ? cfg_i.escape_value : hold_i.item.check;
        phase_nxt = chk_stuffed ? PH_CSUB : PH_CLOSE;
      end
      PH_CSUB: begin
        line_byte = chk_is_flag ? cfg_i.flag_substitute : cfg_i.escape_substitute;
        phase_nxt = PH_CLOSE;
      end
      PH_CLOSE: begin
        line_byte  = cfg_i.flag_value;
        line_end   = 1'b1;
        final_byte = 1'b1;
        phase_nxt  = PH_FLAG;
      end
      default: begin
        final_byte = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    frame_end_d = frame_end_q;
    if (emit && !final_byte) begin
      phase_d = phase_nxt;
    end
    if (load_i.load) begin
      phase_d = load_i.first ? PH_FLAG : PH_DATA;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = line_byte;
      frame_end_d = line_end;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FLAG;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      frame_end_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      frame_end_q <= frame_end_d;
    end
  end

  `SIFE_ASSERT_NOW(a_sub_needs_stuffing, hold_i.valid && (phase_q == PH_DSUB), data_stuffed,
    "substitute byte for an unstuffed payload byte")
  `SIFE_ASSERT_NOW(a_header_on_first,
    hold_i.valid && ((phase_q == PH_FLAG) || (phase_q == PH_ADDR) ||
    (phase_q == PH_CTRL) || (phase_q == PH_HCS)),
    hold_i.item.first, "header emitted inside a frame")
  `SIFE_ASSERT_NOW(a_trailer_on_last,
    hold_i.valid && ((phase_q == PH_CHK) || (phase_q == PH_CSUB) || (phase_q == PH_CLOSE)),
    hold_i.item.last_byte, "trailer emitted before the last byte")

endmodule

FILE: bench/stuffed_info_frame_encoder_tb.sv
module stuffed_info_frame_encoder_tb;
  import sife_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       seq;
  } payload_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       closing;
  } line_byte_t;

  localparam cfg_t ResetCfg = {8'd126, 8'd125, 8'd94, 8'd93, 8'd3, 8'd0, 8'd64};
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int QuietLimit = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_FLAG_VALUE;
  logic [7:0]         cfg_data_i = 8'h00;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i = 8'h00;
  logic               last_byte_i = 1'b0;
  logic               sequence_bit_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               frame_end_o;

  payload_t   pending_q[$];
  line_byte_t expected_line_q[$];
  payload_t   next_payload;
  line_byte_t want;

  cfg_t       line_cfg = ResetCfg;
  logic       frame_open = 1'b0;
  logic [7:0] payload_xor = 8'h00;

  int items_left = 0;
  int items_taken = 0;
  int frames_queued = 0;
  int bytes_checked = 0;
  int settings_used = 1;
  int errors = 0;
  int quiet_cycles = 0;
  int in_idle_pct = 27;
  int out_idle_pct = 27;

  stuffed_info_frame_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .sequence_bit_i(sequence_bit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .frame_end_o   (frame_end_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic emit_line_byte(input logic [7:0] octet, input logic closing);
    line_byte_t b;
    b.octet = octet;
    b.closing = closing;
    expected_line_q.push_back(b);
  endtask

  task automatic emit_stuffed(input logic [7:0] raw);
    if (raw == line_cfg.flag_value) begin
      emit_line_byte(line_cfg.escape_value, 1'b0);
      emit_line_byte(line_cfg.flag_substitute, 1'b0);
    end else if (raw == line_cfg.escape_value) begin
      emit_line_byte(line_cfg.escape_value, 1'b0);
      emit_line_byte(line_cfg.escape_substitute, 1'b0);
    end else begin
      emit_line_byte(raw, 1'b0);
    end
  endtask

  task automatic predict_line_bytes(input payload_t p);
    logic [7:0] ctl;
    if (!frame_open) begin
      ctl = p.seq ? line_cfg.control_seq_one : line_cfg.control_seq_zero;
      emit_line_byte(line_cfg.flag_value, 1'b0);
      emit_line_byte(line_cfg.address_value, 1'b0);
      emit_line_byte(ctl, 1'b0);
      emit_line_byte(line_cfg.address_value ^ ctl, 1'b0);
      payload_xor = 8'h00;
      frame_open = 1'b1;
    end
    emit_stuffed(p.data);
    payload_xor = payload_xor ^ p.data;
    if (p.last) begin
      emit_stuffed(payload_xor);
      emit_line_byte(line_cfg.flag_value, 1'b1);
      frame_open = 1'b0;
      payload_xor = 8'h00;
    end
  endtask

  // drive the next payload transaction, hold a stalled one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_line_bytes({data_byte_i, last_byte_i, sequence_bit_i});
        items_left--;
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          next_payload = pending_q.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= next_payload.data;
          last_byte_i <= next_payload.last;
          sequence_bit_i <= next_payload.seq;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // check line bytes, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        bytes_checked++;
        if (expected_line_q.size() == 0) begin
          report_mismatch($sformatf("unexpected line byte %02h", out_byte_o));
        end else begin
          want = expected_line_q.pop_front();
          if (out_byte_o !== want.octet)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.octet));
          if (frame_end_o !== want.closing)
            report_mismatch($sformatf("frame_end %b, want %b", frame_end_o, want.closing));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no transaction for %0d cycles", QuietLimit);
        $display("stuffed_info_frame_encoder verification failed");
        $finish;
      end
    end
  end

  task automatic push_payload(input logic [7:0] data, input logic last, input logic seq);
    payload_t p;
    p.data = data;
    p.last = last;
    p.seq = seq;
    pending_q.push_back(p);
    items_left++;
    if (last) frames_queued++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FLAG_VALUE:        line_cfg.flag_value = val;
      CFG_ESCAPE_VALUE:      line_cfg.escape_value = val;
      CFG_FLAG_SUBSTITUTE:   line_cfg.flag_substitute = val;
      CFG_ESCAPE_SUBSTITUTE: line_cfg.escape_substitute = val;
      CFG_ADDRESS_VALUE:     line_cfg.address_value = val;
      CFG_CONTROL_SEQ_ZERO:  line_cfg.control_seq_zero = val;
      CFG_CONTROL_SEQ_ONE:   line_cfg.control_seq_one = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(CFG_FLAG_VALUE, c.flag_value);
    write_reg(CFG_ESCAPE_VALUE, c.escape_value);
    write_reg(CFG_FLAG_SUBSTITUTE, c.flag_substitute);
    write_reg(CFG_ESCAPE_SUBSTITUTE, c.escape_substitute);
    write_reg(CFG_ADDRESS_VALUE, c.address_value);
    write_reg(CFG_CONTROL_SEQ_ZERO, c.control_seq_zero);
    write_reg(CFG_CONTROL_SEQ_ONE, c.control_seq_one);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (items_left != 0 || expected_line_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 20) return line_cfg.flag_value;
    if (r < 35) return line_cfg.escape_value;
    return 8'($urandom);
  endfunction

  initial begin
    int ph;
    int n;
    int len;
    int k;
    cfg_t c;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_payload(8'h41, 1'b1, 1'b0);
    push_payload(8'h7E, 1'b0, 1'b1);
    push_payload(8'h7D, 1'b0, 1'b0);
    push_payload(8'h00, 1'b0, 1'b1);
    push_payload(8'hFF, 1'b1, 1'b0);
    push_payload(8'h7E, 1'b1, 1'b1);
    push_payload(8'h7D, 1'b1, 1'b0);
    push_payload(8'h5E, 1'b1, 1'b1);
    wait_idle();

    // flag equals escape, header bytes collide with both
    write_reg(CfgIdxUnused, 8'hA5);
    write_all({8'h55, 8'h55, 8'h00, 8'hFF, 8'h55, 8'h00, 8'h55});
    push_payload(8'h55, 1'b1, 1'b0);
    push_payload(8'h55, 1'b0, 1'b1);
    push_payload(8'h00, 1'b1, 1'b0);
    wait_idle();

    write_all({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    push_payload(8'h00, 1'b1, 1'b1);
    push_payload(8'hFF, 1'b1, 1'b0);
    wait_idle();

    write_all({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    push_payload(8'hFF, 1'b0, 1'b1);
    push_payload(8'h00, 1'b1, 1'b0);
    push_payload(8'h00, 1'b1, 1'b1);
    wait_idle();

    // change the flag in the middle of a frame
    write_all(ResetCfg);
    push_payload(8'h7E, 1'b0, 1'b0);
    wait_idle();
    c = ResetCfg;
    c.flag_value = 8'h41;
    write_all(c);
    push_payload(8'h41, 1'b1, 1'b1);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        c = ResetCfg;
      end else begin
        c.flag_value = 8'($urandom);
        c.escape_value = ($urandom_range(9) == 0) ? c.flag_value : 8'($urandom);
        c.flag_substitute = 8'($urandom);
        c.escape_substitute = 8'($urandom);
        c.address_value = ($urandom_range(4) == 0) ? c.flag_value : 8'($urandom);
        c.control_seq_zero = 8'($urandom);
        c.control_seq_one = ($urandom_range(4) == 0) ? c.escape_value : 8'($urandom);
      end
      in_idle_pct = (ph == 2) ? 0 : 27;
      out_idle_pct = (ph == 2) ? 0 : 27;
      write_all(c);
      n = 0;
      while (n < 75) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (k = 0; k < len; k++)
          push_payload(pick_payload(), k == len - 1, 1'($urandom));
        n += len;
      end
      if (ph == 3) push_payload(pick_payload(), 1'b0, 1'($urandom));
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d payload bytes in %0d closed frames under %0d register settings,",
             items_taken, frames_queued, settings_used);
    $display("with %0d line bytes compared and %0d mismatches.", bytes_checked, errors);
    if (errors == 0) begin
      $display("stuffed_info_frame_encoder verification clean");
    end else begin
      $display("stuffed_info_frame_encoder verification failed");
    end
    $finish;
  end

endmodule
